/* sv/skinned_triangle_bone_cull_defines.svh */
// ----------------------------------------------------------------------------
// Skinned triangle bone cull - assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SKINNED_TRIANGLE_BONE_CULL_DEFINES_SVH
`define SKINNED_TRIANGLE_BONE_CULL_DEFINES_SVH

// Same-cycle implication, sampled on clk, muted while rst_n is low.
`define STBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stbc check failed");

// Next-cycle implication, sampled on clk, muted while rst_n is low.
`define STBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stbc check failed");

`endif

/* sv/stbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_pkg
// Types and constants shared by the skinned triangle bone cull block.
// ----------------------------------------------------------------------------
package stbc_pkg;

  localparam int VERT_W    = 16;
  localparam int BONE_W    = 8;
  localparam int SLOTS     = 4;
  localparam int NUM_BONES = 256;
  localparam int NUM_VERTS = 65536;
  localparam int COUNT_W   = 20;

  localparam logic [COUNT_W-1:0] COUNT_TOP  = COUNT_W'(786432);
  localparam logic [COUNT_W-1:0] COUNT_STEP = COUNT_W'(3);

  typedef enum logic [1:0] {
    OP_EXCL   = 2'd0,
    OP_SKIN   = 2'd1,
    OP_BEGIN  = 2'd2,
    OP_FILTER = 2'd3
  } stbc_op_t;

  // One skin table entry: four bone indices and their live flags.
  typedef struct packed {
    logic [SLOTS-1:0][BONE_W-1:0] bone;
    logic [SLOTS-1:0]             live;
  } skin_entry_t;

endpackage

/* sv/stbc_corner_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_corner_check
// Tests the four slots of one skin entry against the excluded-bone bitmap.
// ----------------------------------------------------------------------------
module stbc_corner_check
  import stbc_pkg::*;
(
  input  skin_entry_t            entry,
  input  logic [NUM_BONES-1:0]   excl_map,
  output logic                   hit
);

  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      hit = hit | (entry.live[s] & excl_map[entry.bone[s]]);
    end
  end

endmodule

/* sv/skinned_triangle_bone_cull.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skinned_triangle_bone_cull
// Filters triangles whose corners carry live weight on an excluded bone.
// ----------------------------------------------------------------------------
// Filter transaction: busy while the three corner skin entries are read in turn
// and a final check is made; the result strobe is registered from that check. The
// single-port skin table reads one corner entry per cycle through one slot checker.
// Exclusion writes, skin loads and list starts finish in the start cycle.
// Synchronous active-low reset clears the bone bitmap, count and skin_present;
// the skin table is not cleared. Results cannot be stalled by the receiver.
module skinned_triangle_bone_cull
  import stbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic [VERT_W-1:0]    in_corner_one,
  input  logic [VERT_W-1:0]    in_corner_two,
  input  logic [VERT_W-1:0]    in_corner_three,
  input  logic [BONE_W-1:0]    in_bone_a,
  input  logic [BONE_W-1:0]    in_bone_b,
  input  logic [BONE_W-1:0]    in_bone_c,
  input  logic [BONE_W-1:0]    in_bone_d,
  input  logic                 in_live_a,
  input  logic                 in_live_b,
  input  logic                 in_live_c,
  input  logic                 in_live_d,
  // result channel
  output logic                 out_valid,
  output logic                 out_keep,
  output logic [VERT_W-1:0]    out_corner_one,
  output logic [VERT_W-1:0]    out_corner_two,
  output logic [VERT_W-1:0]    out_corner_three,
  output logic [COUNT_W-1:0]   out_kept_index_count,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [1:0]             step_r, step_nxt;
  logic                   hit_acc_r, hit_acc_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   skin_present_r, skin_present_nxt;
  logic [NUM_BONES-1:0]   excl_map_r, excl_map_nxt;
  logic [VERT_W-1:0]      c1_r, c2_r, c3_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_keep_r, out_keep_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;

  skin_entry_t            skin_mem [NUM_VERTS];
  skin_entry_t            rd_data_r;
  skin_entry_t            wr_data;
  logic                   mem_wr, mem_rd;
  logic [VERT_W-1:0]      rd_addr;

  logic                   accept;
  logic                   cfg_wr;
  logic                   slot_hit;
  logic                   any_hit;
  logic [COUNT_W:0]       count_sum;
  stbc_op_t               op;

  assign op     = stbc_op_t'(in_opcode);
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, skin_present_r} : 32'b0;

  assign wr_data.bone = {in_bone_d, in_bone_c, in_bone_b, in_bone_a};
  assign wr_data.live = {in_live_d, in_live_c, in_live_b, in_live_a};
  assign mem_wr       = accept && (op == OP_SKIN);
  assign mem_rd       = (state_r == ST_RUN) && (step_r != 2'd3);

  always_comb begin
    case (step_r)
      2'd0:    rd_addr = c1_r;
      2'd1:    rd_addr = c2_r;
      default: rd_addr = c3_r;
    endcase
  end

  // Single-port skin table: loads only while idle, reads only while running.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      skin_mem[in_corner_one] <= wr_data;
    end else if (mem_rd) begin
      rd_data_r <= skin_mem[rd_addr];
    end
  end

  stbc_corner_check u_check (
    .entry    (rd_data_r),
    .excl_map (excl_map_r),
    .hit      (slot_hit)
  );

  assign any_hit   = hit_acc_r | slot_hit;
  assign count_sum = {1'b0, count_r} + {1'b0, COUNT_STEP};

  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    hit_acc_nxt      = hit_acc_r;
    count_nxt        = count_r;
    skin_present_nxt = skin_present_r;
    excl_map_nxt     = excl_map_r;
    out_valid_nxt    = 1'b0;
    out_keep_nxt     = out_keep_r;
    out_count_nxt    = out_count_r;

    if (cfg_wr) begin
      skin_present_nxt = pwdata[0];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_EXCL:   excl_map_nxt[in_bone_a] = in_live_a;
            OP_BEGIN:  count_nxt = '0;
            OP_FILTER: begin
              state_nxt   = ST_RUN;
              step_nxt    = 2'd0;
              hit_acc_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // accumulate the corner fetched last cycle
        if (step_r != 2'd0) begin
          hit_acc_nxt = any_hit;
        end
        if (step_r == 2'd3) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_keep_nxt  = skin_present_r && !any_hit;
          if (skin_present_r && !any_hit) begin
            count_nxt = (count_sum > {1'b0, COUNT_TOP}) ? COUNT_TOP
                                                        : count_sum[COUNT_W-1:0];
          end
          out_count_nxt = (skin_present_r && !any_hit) ? count_nxt : count_r;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      step_r         <= '0;
      hit_acc_r      <= 1'b0;
      count_r        <= '0;
      skin_present_r <= 1'b0;
      excl_map_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      step_r         <= step_nxt;
      hit_acc_r      <= hit_acc_nxt;
      count_r        <= count_nxt;
      skin_present_r <= skin_present_nxt;
      excl_map_r     <= excl_map_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload holds: capture corners on a filter accept, result fields at the final step.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_FILTER)) begin
      c1_r <= in_corner_one;
      c2_r <= in_corner_two;
      c3_r <= in_corner_three;
    end
    out_keep_r  <= out_keep_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_keep             = out_keep_r;
  assign out_corner_one       = c1_r;
  assign out_corner_two       = c2_r;
  assign out_corner_three     = c3_r;
  assign out_kept_index_count = out_count_r;

endmodule

/* sv/stbc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_checker
// Port-level checks on the bone cull command and result channels.
// ----------------------------------------------------------------------------
`include "skinned_triangle_bone_cull_defines.svh"

module stbc_checker
  import stbc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_opcode,
  input logic               out_valid,
  input logic               out_keep,
  input logic [COUNT_W-1:0] out_kept_index_count
);

  `STBC_ASSERT_NEXT(a_filter_goes_busy, start && !busy && in_opcode == OP_FILTER, busy)
  `STBC_ASSERT_NEXT(a_other_ops_stay_idle, start && !busy && in_opcode != OP_FILTER, !busy)
  `STBC_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `STBC_ASSERT_NOW(a_result_when_idle, out_valid, !busy)
  `STBC_ASSERT_NOW(a_count_bounded, out_valid, out_kept_index_count <= COUNT_TOP && (!out_keep || out_kept_index_count >= COUNT_STEP))

endmodule

bind skinned_triangle_bone_cull stbc_checker u_stbc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .in_opcode            (in_opcode),
  .out_valid            (out_valid),
  .out_keep             (out_keep),
  .out_kept_index_count (out_kept_index_count)
);
